// File: sv/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg: park-exit classifier shared definitions
// Codes, register indexes, reset values and the corner extrapolation constants.
// ----------------------------------------------------------------------------
package pec_pkg;

  // Mounting geometry of the side sensors
  localparam int OVERHANG_MM       = 500;
  localparam int SENSOR_SPACING_MM = 1000;

  // Field widths
  localparam int DIST_W  = 16;
  localparam int FLAGS_W = 7;
  localparam int INDEX_W = 3;

  // Corner extrapolation: floor(x * OVERHANG_MM / SENSOR_SPACING_MM) is taken
  // as (x * PRED_MULT) >> PRED_SHIFT, exact for any 16-bit x because the
  // rounding error stays below 1 / SENSOR_SPACING_MM.
  localparam int      PRED_SHIFT  = 30;
  localparam longint  PRED_MULT   = ((longint'(OVERHANG_MM) << PRED_SHIFT)
                                     + longint'(SENSOR_SPACING_MM) - 1)
                                    / longint'(SENSOR_SPACING_MM);
  localparam int      PRED_MULT_W = (PRED_MULT > 1) ? $clog2(PRED_MULT + 1) : 1;
  localparam int      PROD_W      = DIST_W + PRED_MULT_W;
  localparam int      QUOT_W      = 29;
  localparam int      PRED_W      = 32;

  // Exit direction codes
  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_LEFT     = 2'd1,
    DIR_RIGHT    = 2'd2,
    DIR_RIGHT_ALT = 2'd3
  } dir_t;

  // Strategy codes
  typedef enum logic [1:0] {
    STRAT_NORMAL  = 2'd0,
    STRAT_AVOID   = 2'd1,
    STRAT_BLOCKED = 2'd2
  } strategy_t;

  // Exit-side risk codes
  typedef enum logic [2:0] {
    RISK_SAFE       = 3'd0,
    RISK_CRITICAL   = 3'd1,
    RISK_NARROW     = 3'd2,
    RISK_NEAR_FRONT = 3'd3,
    RISK_NEAR_REAR  = 3'd4,
    RISK_TILT_FRONT = 3'd5,
    RISK_TILT_REAR  = 3'd6
  } risk_t;

  // Steering codes
  typedef enum logic [1:0] {
    STEER_CENTER = 2'd0,
    STEER_LEFT   = 2'd1,
    STEER_RIGHT  = 2'd2
  } steer_t;

  // Configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_CRITICAL_DISTANCE  = 3'd0,
    REG_NEAR_DISTANCE      = 3'd1,
    REG_CLEAR_DISTANCE     = 3'd2,
    REG_TILT_DIFFERENCE    = 3'd3,
    REG_ESCAPE_TIME_LONG   = 3'd4,
    REG_REALIGN_TIME_LONG  = 3'd5,
    REG_ESCAPE_TIME_SHORT  = 3'd6,
    REG_REALIGN_TIME_SHORT = 3'd7
  } reg_index_t;

  // Register reset values
  localparam logic [DIST_W-1:0] CRITICAL_DISTANCE_RST  = 16'd300;
  localparam logic [DIST_W-1:0] NEAR_DISTANCE_RST      = 16'd600;
  localparam logic [DIST_W-1:0] CLEAR_DISTANCE_RST     = 16'd1200;
  localparam logic [DIST_W-1:0] TILT_DIFFERENCE_RST    = 16'd150;
  localparam logic [DIST_W-1:0] ESCAPE_TIME_LONG_RST   = 16'd2000;
  localparam logic [DIST_W-1:0] REALIGN_TIME_LONG_RST  = 16'd2000;
  localparam logic [DIST_W-1:0] ESCAPE_TIME_SHORT_RST  = 16'd1000;
  localparam logic [DIST_W-1:0] REALIGN_TIME_SHORT_RST = 16'd1000;

  // Danger flag bit positions
  localparam int DF_FRONT        = 0;
  localparam int DF_CORNER_LEFT  = 1;
  localparam int DF_CORNER_RIGHT = 2;
  localparam int DF_LEFT_FRONT   = 3;
  localparam int DF_LEFT_REAR    = 4;
  localparam int DF_RIGHT_FRONT  = 5;
  localparam int DF_RIGHT_REAR   = 6;

  // One sensor snapshot
  typedef struct packed {
    logic [1:0]         exit_direction;
    logic               sensors_ok;
    logic [DIST_W-1:0]  left_front_mm;
    logic [DIST_W-1:0]  left_rear_mm;
    logic [DIST_W-1:0]  right_front_mm;
    logic [DIST_W-1:0]  right_rear_mm;
    logic [DIST_W-1:0]  corner_left_mm;
    logic [DIST_W-1:0]  corner_right_mm;
    logic [FLAGS_W-1:0] danger_flags;
  } snap_t;

  // One classification result
  typedef struct packed {
    strategy_t         strategy;
    risk_t             exit_risk;
    logic [DIST_W-1:0] escape_ms;
    logic [DIST_W-1:0] realign_ms;
    steer_t            escape_steer;
    steer_t            realign_steer;
  } result_t;

endpackage

// File: sv/pec_if.sv
// ----------------------------------------------------------------------------
// pec_if: park-exit classifier channels
// Snapshot input, result output and register write channels.
// ----------------------------------------------------------------------------
interface pec_snap_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  exit_direction;
  logic                        sensors_ok;
  logic [pec_pkg::DIST_W-1:0]  left_front_mm;
  logic [pec_pkg::DIST_W-1:0]  left_rear_mm;
  logic [pec_pkg::DIST_W-1:0]  right_front_mm;
  logic [pec_pkg::DIST_W-1:0]  right_rear_mm;
  logic [pec_pkg::DIST_W-1:0]  corner_left_mm;
  logic [pec_pkg::DIST_W-1:0]  corner_right_mm;
  logic [pec_pkg::FLAGS_W-1:0] danger_flags;

  modport source (
    output valid, exit_direction, sensors_ok, left_front_mm, left_rear_mm,
           right_front_mm, right_rear_mm, corner_left_mm, corner_right_mm,
           danger_flags,
    input  ready
  );
  modport sink (
    input  valid, exit_direction, sensors_ok, left_front_mm, left_rear_mm,
           right_front_mm, right_rear_mm, corner_left_mm, corner_right_mm,
           danger_flags,
    output ready
  );
endinterface

interface pec_result_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 strategy;
  logic [2:0]                 exit_risk;
  logic [pec_pkg::DIST_W-1:0] escape_ms;
  logic [pec_pkg::DIST_W-1:0] realign_ms;
  logic [1:0]                 escape_steer;
  logic [1:0]                 realign_steer;

  modport source (
    output valid, strategy, exit_risk, escape_ms, realign_ms, escape_steer,
           realign_steer,
    input  ready
  );
  modport sink (
    input  valid, strategy, exit_risk, escape_ms, realign_ms, escape_steer,
           realign_steer,
    output ready
  );
endinterface

interface pec_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pec_pkg::INDEX_W-1:0] index;
  logic [pec_pkg::DIST_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/park_exit_strategy_classifier.sv
// ----------------------------------------------------------------------------
// park_exit_strategy_classifier: exit-side risk and strategy selection
// Classifies one parking-sensor snapshot per transaction into a strategy,
// an exit-side risk code, avoidance durations and steering directions.
// ----------------------------------------------------------------------------
// Usage:
//   snap   - sink channel, one sensor snapshot per transaction.
//   result - source channel, exactly one result per accepted snapshot,
//            delivered in order.
//   cfg    - register write channel, always ready; write only while idle.
// Pipeline: an accepted snapshot goes through the input register, then the
//   result register, before it is presented on result.
// Throughput: one transaction per cycle while result.ready is high. The whole
//   classification, including the constant multiply of the corner
//   extrapolation, sits between the input register and the result register.
// Reset (rst, synchronous): both pipeline stages empty, registers return to
//   their default thresholds and durations.
// Stall: when result.ready is low the result register holds; the input
//   register still takes one more snapshot, then snap.ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module park_exit_strategy_classifier (
  input  logic               clk,
  input  logic               rst,
  pec_snap_if.sink           snap,
  pec_result_if.source       result,
  pec_cfg_if.sink            cfg
);

  // Configuration registers
  logic [pec_pkg::DIST_W-1:0] critical_distance;
  logic [pec_pkg::DIST_W-1:0] near_distance;
  logic [pec_pkg::DIST_W-1:0] clear_distance;
  logic [pec_pkg::DIST_W-1:0] tilt_difference;
  logic [pec_pkg::DIST_W-1:0] escape_time_long;
  logic [pec_pkg::DIST_W-1:0] realign_time_long;
  logic [pec_pkg::DIST_W-1:0] escape_time_short;
  logic [pec_pkg::DIST_W-1:0] realign_time_short;

  // Pipeline registers
  logic               s1_valid;
  pec_pkg::snap_t     s1;
  logic               res_valid;
  pec_pkg::result_t   res;
  pec_pkg::result_t   res_next;

  logic snap_accept;
  logic advance;

  // Classify one side from its front and rear distances
  function automatic pec_pkg::risk_t classify_side(
    input logic [pec_pkg::DIST_W-1:0] front,
    input logic [pec_pkg::DIST_W-1:0] rear,
    input logic [pec_pkg::DIST_W-1:0] crit,
    input logic [pec_pkg::DIST_W-1:0] near,
    input logic [pec_pkg::DIST_W-1:0] far,
    input logic [pec_pkg::DIST_W-1:0] tilt
  );
    logic signed [pec_pkg::DIST_W:0]   diff;
    logic        [pec_pkg::DIST_W-1:0] abs_diff;
    logic        [pec_pkg::PROD_W-1:0] prod;
    logic        [pec_pkg::QUOT_W-1:0] quot;
    logic signed [pec_pkg::PRED_W-1:0] front_s;
    logic signed [pec_pkg::PRED_W-1:0] quot_s;
    logic signed [pec_pkg::PRED_W-1:0] pred;
    logic signed [pec_pkg::PRED_W-1:0] far_s;
    logic signed [pec_pkg::PRED_W-1:0] near_s;
    logic signed [pec_pkg::DIST_W+1:0] diff_w;
    logic signed [pec_pkg::DIST_W+1:0] tilt_w;
    logic        [pec_pkg::DIST_W-1:0] nearer;
    logic                              side_clear;
    pec_pkg::risk_t                    risk;

    diff     = $signed({1'b0, front}) - $signed({1'b0, rear});
    abs_diff = diff[pec_pkg::DIST_W] ? pec_pkg::DIST_W'(rear - front)
                                     : pec_pkg::DIST_W'(front - rear);
    // Extrapolate the front corner; truncation toward zero on the magnitude
    prod     = pec_pkg::PROD_W'(abs_diff)
             * pec_pkg::PROD_W'(pec_pkg::PRED_MULT);
    quot     = pec_pkg::QUOT_W'(prod >> pec_pkg::PRED_SHIFT);
    front_s  = $signed(pec_pkg::PRED_W'(front));
    quot_s   = $signed(pec_pkg::PRED_W'(quot));
    pred     = diff[pec_pkg::DIST_W] ? (front_s - quot_s) : (front_s + quot_s);
    if (pred < 0) begin
      pred = '0;
    end
    far_s    = $signed(pec_pkg::PRED_W'(far));
    near_s   = $signed(pec_pkg::PRED_W'(near));
    diff_w   = (pec_pkg::DIST_W + 2)'(diff);
    tilt_w   = $signed((pec_pkg::DIST_W + 2)'(tilt));
    nearer   = (front < rear) ? front : rear;
    side_clear = (front >= far) && (rear >= far) && (pred >= far_s);

    if (nearer < crit) begin
      risk = pec_pkg::RISK_CRITICAL;
    end else if (side_clear) begin
      risk = pec_pkg::RISK_SAFE;
    end else if (front < near && rear < near) begin
      risk = pec_pkg::RISK_NARROW;
    end else if (front < near) begin
      risk = pec_pkg::RISK_NEAR_FRONT;
    end else if (rear < near) begin
      risk = pec_pkg::RISK_NEAR_REAR;
    end else if (pred < near_s) begin
      risk = pec_pkg::RISK_TILT_FRONT;
    end else if (diff_w < -tilt_w) begin
      risk = pec_pkg::RISK_TILT_FRONT;
    end else if (diff_w > tilt_w) begin
      risk = pec_pkg::RISK_TILT_REAR;
    end else begin
      risk = pec_pkg::RISK_SAFE;
    end
    return risk;
  endfunction

  // Handshakes
  assign snap_accept = snap.valid && snap.ready;
  assign advance     = s1_valid && (!res_valid || result.ready);
  assign snap.ready  = !s1_valid || advance;
  assign cfg.ready   = 1'b1;

  // Classify the registered snapshot
  always_comb begin
    logic                         left;
    logic                         blocked_early;
    logic [pec_pkg::DIST_W-1:0]   opp_f;
    logic [pec_pkg::DIST_W-1:0]   opp_r;
    logic [pec_pkg::DIST_W-1:0]   opp_c;
    logic                         opp_flag;
    logic                         is_long;
    pec_pkg::risk_t               risk;

    left          = (s1.exit_direction == pec_pkg::DIR_LEFT);
    blocked_early = s1.danger_flags[pec_pkg::DF_FRONT] ||
                    (left ? s1.danger_flags[pec_pkg::DF_CORNER_LEFT]
                          : s1.danger_flags[pec_pkg::DF_CORNER_RIGHT]);
    opp_f    = left ? s1.right_front_mm  : s1.left_front_mm;
    opp_r    = left ? s1.right_rear_mm   : s1.left_rear_mm;
    opp_c    = left ? s1.corner_right_mm : s1.corner_left_mm;
    opp_flag = left ? (s1.danger_flags[pec_pkg::DF_RIGHT_FRONT] ||
                       s1.danger_flags[pec_pkg::DF_RIGHT_REAR]  ||
                       s1.danger_flags[pec_pkg::DF_CORNER_RIGHT])
                    : (s1.danger_flags[pec_pkg::DF_LEFT_FRONT] ||
                       s1.danger_flags[pec_pkg::DF_LEFT_REAR]  ||
                       s1.danger_flags[pec_pkg::DF_CORNER_LEFT]);
    risk = left ? classify_side(s1.left_front_mm, s1.left_rear_mm,
                                critical_distance, near_distance,
                                clear_distance, tilt_difference)
                : classify_side(s1.right_front_mm, s1.right_rear_mm,
                                critical_distance, near_distance,
                                clear_distance, tilt_difference);
    is_long = (risk == pec_pkg::RISK_CRITICAL) || (risk == pec_pkg::RISK_NARROW) ||
              (risk == pec_pkg::RISK_NEAR_FRONT) || (risk == pec_pkg::RISK_TILT_FRONT);

    res_next.strategy      = pec_pkg::STRAT_NORMAL;
    res_next.exit_risk     = pec_pkg::RISK_SAFE;
    res_next.escape_ms     = '0;
    res_next.realign_ms    = '0;
    res_next.escape_steer  = pec_pkg::STEER_CENTER;
    res_next.realign_steer = pec_pkg::STEER_CENTER;

    if (s1.exit_direction != pec_pkg::DIR_STRAIGHT && s1.sensors_ok) begin
      if (blocked_early) begin
        res_next.strategy = pec_pkg::STRAT_BLOCKED;
      end else begin
        res_next.exit_risk = risk;
        if (risk == pec_pkg::RISK_SAFE) begin
          res_next.strategy = pec_pkg::STRAT_NORMAL;
        end else if (opp_f < critical_distance || opp_r < critical_distance ||
                     opp_c < critical_distance || opp_flag) begin
          res_next.strategy = pec_pkg::STRAT_BLOCKED;
        end else begin
          res_next.strategy      = pec_pkg::STRAT_AVOID;
          res_next.escape_ms     = is_long ? escape_time_long : escape_time_short;
          res_next.realign_ms    = is_long ? realign_time_long : realign_time_short;
          res_next.escape_steer  = left ? pec_pkg::STEER_RIGHT : pec_pkg::STEER_LEFT;
          res_next.realign_steer = left ? pec_pkg::STEER_LEFT : pec_pkg::STEER_RIGHT;
        end
      end
    end
  end

  // Advance pipeline control and take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      res_valid          <= 1'b0;
      critical_distance  <= pec_pkg::CRITICAL_DISTANCE_RST;
      near_distance      <= pec_pkg::NEAR_DISTANCE_RST;
      clear_distance     <= pec_pkg::CLEAR_DISTANCE_RST;
      tilt_difference    <= pec_pkg::TILT_DIFFERENCE_RST;
      escape_time_long   <= pec_pkg::ESCAPE_TIME_LONG_RST;
      realign_time_long  <= pec_pkg::REALIGN_TIME_LONG_RST;
      escape_time_short  <= pec_pkg::ESCAPE_TIME_SHORT_RST;
      realign_time_short <= pec_pkg::REALIGN_TIME_SHORT_RST;
    end else begin
      if (snap_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (pec_pkg::reg_index_t'(cfg.index))
          pec_pkg::REG_CRITICAL_DISTANCE:  critical_distance  <= cfg.data;
          pec_pkg::REG_NEAR_DISTANCE:      near_distance      <= cfg.data;
          pec_pkg::REG_CLEAR_DISTANCE:     clear_distance     <= cfg.data;
          pec_pkg::REG_TILT_DIFFERENCE:    tilt_difference    <= cfg.data;
          pec_pkg::REG_ESCAPE_TIME_LONG:   escape_time_long   <= cfg.data;
          pec_pkg::REG_REALIGN_TIME_LONG:  realign_time_long  <= cfg.data;
          pec_pkg::REG_ESCAPE_TIME_SHORT:  escape_time_short  <= cfg.data;
          pec_pkg::REG_REALIGN_TIME_SHORT: realign_time_short <= cfg.data;
          default: begin
          end
        endcase
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (snap_accept) begin
      s1.exit_direction  <= snap.exit_direction;
      s1.sensors_ok      <= snap.sensors_ok;
      s1.left_front_mm   <= snap.left_front_mm;
      s1.left_rear_mm    <= snap.left_rear_mm;
      s1.right_front_mm  <= snap.right_front_mm;
      s1.right_rear_mm   <= snap.right_rear_mm;
      s1.corner_left_mm  <= snap.corner_left_mm;
      s1.corner_right_mm <= snap.corner_right_mm;
      s1.danger_flags    <= snap.danger_flags;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // Drive the result channel
  assign result.valid         = res_valid;
  assign result.strategy      = res.strategy;
  assign result.exit_risk     = res.exit_risk;
  assign result.escape_ms     = res.escape_ms;
  assign result.realign_ms    = res.realign_ms;
  assign result.escape_steer  = res.escape_steer;
  assign result.realign_steer = res.realign_steer;

  // Both stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!result.valid && snap.ready))
    else $error("pipeline not empty after reset");

  // Durations and steering only accompany an avoidance result
  a_avoid_only: assert property (@(posedge clk) disable iff (rst)
    (result.valid && res.strategy != pec_pkg::STRAT_AVOID) |->
      (result.escape_ms == '0 && result.realign_ms == '0 &&
       res.escape_steer == pec_pkg::STEER_CENTER &&
       res.realign_steer == pec_pkg::STEER_CENTER))
    else $error("avoidance fields set outside avoid strategy");

  // Avoidance steers away and then back
  a_avoid_steer: assert property (@(posedge clk) disable iff (rst)
    (result.valid && res.strategy == pec_pkg::STRAT_AVOID) |->
      (res.escape_steer != pec_pkg::STEER_CENTER &&
       res.realign_steer != pec_pkg::STEER_CENTER &&
       res.escape_steer != res.realign_steer))
    else $error("inconsistent avoidance steering");

  // A full input stage behind a stalled result blocks new snapshots
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res_valid && !result.ready) |-> !snap.ready)
    else $error("snapshot accepted with both stages full");

  // A snapshot accepted while the output is free is in the input stage the cycle after
  a_forward: assert property (@(posedge clk) disable iff (rst)
    (snap_accept && !s1_valid && (!res_valid || result.ready)) |=> s1_valid)
    else $error("accepted snapshot lost from input stage");

endmodule
